// ===== rtl/bfill_pkg.sv =====
// Shared types and codes for the wrapped rectangle fill board.
`timescale 1ns / 1ps

package bfill_pkg;

    // Cell codes written by clear and by overlapping draws.
    localparam logic [7:0] EMPTY_CODE   = 8'd46;
    localparam logic [7:0] OVERLAP_CODE = 8'd35;

    // Coordinates are 7-bit signed, so they never go below minus this span.
    localparam int COORD_SPAN = 64;

    // Operation codes; the fourth code is unused.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_SETUP,
        ST_DRAW,
        ST_READ,
        ST_READ_DATA,
        ST_RESULT
    } seq_state_t;

    // One command as presented on the input channel.
    typedef struct packed {
        logic [1:0]        op;
        logic signed [6:0] left_x;
        logic signed [6:0] top_y;
        logic signed [6:0] right_x;
        logic signed [6:0] bottom_y;
        logic [7:0]        fill_symbol;
        logic [4:0]        read_col;
        logic [4:0]        read_row;
    } cmd_t;

    // One result as handed to the output stage.
    typedef struct packed {
        logic [7:0] cell_value;
        logic       op_done;
    } res_t;

endpackage

// ===== rtl/bfill_board_mem.sv =====
// Board cell storage: one write port and one registered read port.
`timescale 1ns / 1ps

module bfill_board_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rdata_reg;

    // Synchronous write and read; read data is registered and appears in the cycle after the address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bfill_seq.sv =====
// Command sequencer: clear sweep, rectangle read-modify-write walk and cell read.
`timescale 1ns / 1ps

module bfill_seq
    import bfill_pkg::*;
#(
    parameter int BOARD_DIM = 32,
    parameter int ADDR_W    = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    output res_t              res,
    output logic              res_valid,
    input  logic              res_ready,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [7:0]        mem_rdata
);

    localparam int CW = (BOARD_DIM > 1) ? $clog2(BOARD_DIM) : 1;
    localparam int CELLS = BOARD_DIM * BOARD_DIM;
    // Multiple of the board size that lifts any coordinate to a non-negative value.
    localparam int WRAP_OFS = BOARD_DIM * ((COORD_SPAN + BOARD_DIM - 1) / BOARD_DIM);
    localparam logic [7:0] WRAP_OFS8 = 8'(WRAP_OFS);
    localparam logic [CW-1:0] LAST_IDX = CW'(BOARD_DIM - 1);
    localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(BOARD_DIM);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    // Remainder by the board size through eight conditional subtractions.
    function automatic logic [CW-1:0] wrap_mod(input logic [7:0] u);
        logic [15:0] rem;
        rem = {8'd0, u};
        for (int k = 7; k >= 0; k--) begin
            if (rem >= (16'(BOARD_DIM) << k)) begin
                rem = rem - (16'(BOARD_DIM) << k);
            end
        end
        return rem[CW-1:0];
    endfunction

    seq_state_t        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic              reply_reg, reply_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [CW-1:0]     wx_reg, wx_next;
    logic [CW-1:0]     wx_start_reg, wx_start_next;
    logic [CW-1:0]     wy_reg, wy_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [7:0]        col_span_reg, col_span_next;
    logic [7:0]        col_left_reg, col_left_next;
    logic [7:0]        row_left_reg, row_left_next;
    logic              p_valid_reg, p_valid_next;
    logic [ADDR_W-1:0] p_addr_reg, p_addr_next;
    logic [7:0]        res_value_reg, res_value_next;
    logic              res_done_reg, res_done_next;

    logic signed [7:0] col_diff;
    logic signed [7:0] row_diff;
    logic [CW-1:0]     wx_start_w;
    logic [CW-1:0]     wy_start_w;
    logic [7:0]        merged;

    // Span of the rectangle less one; negative means an empty range.
    assign col_diff = $signed({cmd_reg.right_x[6], cmd_reg.right_x})
                    - $signed({cmd_reg.left_x[6], cmd_reg.left_x});
    assign row_diff = $signed({cmd_reg.bottom_y[6], cmd_reg.bottom_y})
                    - $signed({cmd_reg.top_y[6], cmd_reg.top_y});

    // Wrapped start position for a draw, or the wrapped cell of a read.
    always_comb begin
        if (cmd_reg.op == OP_READ) begin
            wx_start_w = wrap_mod({3'd0, cmd_reg.read_col});
            wy_start_w = wrap_mod({3'd0, cmd_reg.read_row});
        end else begin
            wx_start_w = wrap_mod(8'({cmd_reg.left_x[6], cmd_reg.left_x}) + WRAP_OFS8);
            wy_start_w = wrap_mod(8'({cmd_reg.top_y[6], cmd_reg.top_y}) + WRAP_OFS8);
        end
    end

    // Overlap rule applied to the cell just read back.
    assign merged = (mem_rdata != EMPTY_CODE && mem_rdata != cmd_reg.fill_symbol)
                  ? OVERLAP_CODE : cmd_reg.fill_symbol;

    // Read address always follows the walk position.
    assign mem_raddr = row_base_reg + ADDR_W'(wx_reg);

    // Write port: the clearing sweep, otherwise the pending draw write-back.
    always_comb begin
        if (state_reg == ST_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = EMPTY_CODE;
        end else begin
            mem_we    = p_valid_reg;
            mem_waddr = p_addr_reg;
            mem_wdata = merged;
        end
    end

    assign cmd_ready     = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_RESULT);
    assign res.cell_value = res_value_reg;
    assign res.op_done    = res_done_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            reply_reg      <= 1'b0;
            sweep_addr_reg <= '0;
            p_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            reply_reg      <= reply_next;
            sweep_addr_reg <= sweep_addr_next;
            p_valid_reg    <= p_valid_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        wx_reg        <= wx_next;
        wx_start_reg  <= wx_start_next;
        wy_reg        <= wy_next;
        row_base_reg  <= row_base_next;
        col_span_reg  <= col_span_next;
        col_left_reg  <= col_left_next;
        row_left_reg  <= row_left_next;
        p_addr_reg    <= p_addr_next;
        res_value_reg <= res_value_next;
        res_done_reg  <= res_done_next;
    end

    // Next state and walk control. A revisited cell is read again only after
    // its write-back has landed.
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        reply_next      = reply_reg;
        sweep_addr_next = sweep_addr_reg;
        wx_next         = wx_reg;
        wx_start_next   = wx_start_reg;
        wy_next         = wy_reg;
        row_base_next   = row_base_reg;
        col_span_next   = col_span_reg;
        col_left_next   = col_left_reg;
        row_left_next   = row_left_reg;
        p_valid_next    = 1'b0;
        p_addr_next     = mem_raddr;
        res_value_next  = res_value_reg;
        res_done_next   = res_done_reg;

        unique case (state_reg)
            ST_SWEEP: begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == LAST_CELL) begin
                    sweep_addr_next = '0;
                    state_next      = reply_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next       = cmd;
                    res_value_next = 8'd0;
                    res_done_next  = 1'b1;
                    unique case (cmd.op) inside
                        OP_CLEAR: begin
                            reply_next = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        OP_DRAW, OP_READ: begin
                            state_next = ST_SETUP;
                        end
                        default: begin
                            res_done_next = 1'b0;
                            state_next    = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                wx_next       = wx_start_w;
                wx_start_next = wx_start_w;
                wy_next       = wy_start_w;
                row_base_next = ADDR_W'(ADDR_W'(wy_start_w) * DIM_A);
                col_span_next = col_diff;
                col_left_next = col_diff;
                row_left_next = row_diff;
                if (cmd_reg.op == OP_READ) begin
                    state_next = ST_READ;
                end else if (col_diff[7] || row_diff[7]) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                p_valid_next = 1'b1;
                if (col_left_reg == 8'd0) begin
                    if (row_left_reg == 8'd0) begin
                        state_next = ST_RESULT;
                    end else begin
                        row_left_next = row_left_reg - 8'd1;
                        col_left_next = col_span_reg;
                        wx_next       = wx_start_reg;
                        if (wy_reg == LAST_IDX) begin
                            wy_next       = '0;
                            row_base_next = '0;
                        end else begin
                            wy_next       = wy_reg + 1'b1;
                            row_base_next = row_base_reg + DIM_A;
                        end
                    end
                end else begin
                    col_left_next = col_left_reg - 8'd1;
                    wx_next       = (wx_reg == LAST_IDX) ? '0 : wx_reg + 1'b1;
                end
            end
            ST_READ: begin
                state_next = ST_READ_DATA;
            end
            ST_READ_DATA: begin
                res_value_next = mem_rdata;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (res_ready) begin
                    reply_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/wrapped_rectangle_fill_with_overlap.sv =====
// Top level of the wrapped rectangle fill board with its output register.
//
// Usage: commands enter on the s_ channel (valid/ready); each produces one
// transaction on the m_ channel carrying cell_value and op_done.
// Clear rewrites every cell, one per cycle. Draw does one read-modify-write
// per visited cell through the single board memory, pipelined one cell per
// cycle. An empty range goes from setup straight to the result; a read passes
// through setup and its address and data states before the result.
// The board memory's one write port sets the clear time; its read latency
// sets the read time. One command is worked on at a time.
// After reset the board is swept to the empty code with s_ready low. A
// finished result sits in the output register while the next command is
// accepted; if m_ready stays low, the following result waits inside the
// sequencer and s_ready stays low until it moves.
`timescale 1ns / 1ps

module wrapped_rectangle_fill_with_overlap
    import bfill_pkg::*;
#(
    parameter int BOARD_DIM = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic signed [6:0] s_left_x,
    input  logic signed [6:0] s_top_y,
    input  logic signed [6:0] s_right_x,
    input  logic signed [6:0] s_bottom_y,
    input  logic [7:0]        s_fill_symbol,
    input  logic [4:0]        s_read_col,
    input  logic [4:0]        s_read_row,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_cell_value,
    output logic              m_op_done
);

    localparam int CELLS  = BOARD_DIM * BOARD_DIM;
    localparam int ADDR_W = $clog2(CELLS);

    cmd_t              cmd;
    res_t              res;
    logic              res_valid;
    logic              res_ready;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    logic              m_valid_reg;
    logic [7:0]        m_cell_value_reg;
    logic              m_op_done_reg;

    // Gather the input fields into one command.
    assign cmd.op          = s_op;
    assign cmd.left_x      = s_left_x;
    assign cmd.top_y       = s_top_y;
    assign cmd.right_x     = s_right_x;
    assign cmd.bottom_y    = s_bottom_y;
    assign cmd.fill_symbol = s_fill_symbol;
    assign cmd.read_col    = s_read_col;
    assign cmd.read_row    = s_read_row;

    bfill_seq #(
        .BOARD_DIM (BOARD_DIM),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bfill_board_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a result whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_cell_value_reg <= res.cell_value;
            m_op_done_reg    <= res.op_done;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_value = m_cell_value_reg;
    assign m_op_done    = m_op_done_reg;

endmodule

// ===== sim/board_fill_checker.sv =====
// Checker for the wrapped rectangle fill board: predicts each command and compares results.
`timescale 1ns / 1ps

module board_fill_checker
    import bfill_pkg::*;
#(
    parameter int BOARD_DIM    = 32,
    parameter int REPORT_LIMIT = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic signed [6:0] s_left_x,
    input  logic signed [6:0] s_top_y,
    input  logic signed [6:0] s_right_x,
    input  logic signed [6:0] s_bottom_y,
    input  logic [7:0]        s_fill_symbol,
    input  logic [4:0]        s_read_col,
    input  logic [4:0]        s_read_row,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [7:0]        m_cell_value,
    input  logic              m_op_done,
    output int                error_count,
    output int                results_outstanding,
    output int                results_checked
);

    localparam int CELL_COUNT = BOARD_DIM * BOARD_DIM;

    // Shadow copy of the board and the results still owed by the block.
    logic [7:0] board_shadow [CELL_COUNT];
    res_t       awaited_results [$];
    res_t       want;
    int         mismatch_total = 0;
    int         results_seen   = 0;

    // True modulo, so negative coordinates land on the far side of the board.
    function automatic int wrap_coord(input int v);
        int m;
        m = v % BOARD_DIM;
        if (m < 0) begin
            m += BOARD_DIM;
        end
        return m;
    endfunction

    // Apply one command to the shadow board and return the result it owes.
    function automatic res_t apply_command(
        input logic [1:0] op,
        input int         x0,
        input int         y0,
        input int         x1,
        input int         y1,
        input logic [7:0] sym,
        input int         col,
        input int         row
    );
        res_t       res;
        int         idx;
        logic [7:0] cur;
        res = '0;
        case (op)
            OP_CLEAR: begin
                foreach (board_shadow[i]) begin
                    board_shadow[i] = EMPTY_CODE;
                end
                res.op_done = 1'b1;
            end
            OP_DRAW: begin
                // Cells holding some other symbol turn into the overlap code.
                for (int r = y0; r <= y1; r++) begin
                    for (int c = x0; c <= x1; c++) begin
                        idx = wrap_coord(r) * BOARD_DIM + wrap_coord(c);
                        cur = board_shadow[idx];
                        if (cur != EMPTY_CODE && cur != sym) begin
                            board_shadow[idx] = OVERLAP_CODE;
                        end else begin
                            board_shadow[idx] = sym;
                        end
                    end
                end
                res.op_done = 1'b1;
            end
            OP_READ: begin
                res.cell_value = board_shadow[wrap_coord(row) * BOARD_DIM + wrap_coord(col)];
                res.op_done    = 1'b1;
            end
            default: begin
                // The unused code leaves the board alone and reports not done.
                res = '0;
            end
        endcase
        return res;
    endfunction

    // Compare result transactions first, then predict the newly accepted command.
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (board_shadow[i]) begin
                board_shadow[i] = EMPTY_CODE;
            end
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    if (mismatch_total < REPORT_LIMIT) begin
                        $display("Unexpected result transaction %0d: cell_value %02h op_done %0b",
                                 results_seen, m_cell_value, m_op_done);
                    end
                    mismatch_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_cell_value !== want.cell_value || m_op_done !== want.op_done) begin
                        if (mismatch_total < REPORT_LIMIT) begin
                            $display("Result %0d mismatch: cell_value expected %02h got %02h, %s",
                                     results_seen, want.cell_value, m_cell_value,
                                     $sformatf("op_done expected %0b got %0b",
                                               want.op_done, m_op_done));
                        end
                        mismatch_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_command(
                    s_op, int'(s_left_x), int'(s_top_y), int'(s_right_x), int'(s_bottom_y),
                    s_fill_symbol, int'(s_read_col), int'(s_read_row)));
            end
        end
        error_count         <= mismatch_total;
        results_outstanding <= awaited_results.size();
        results_checked     <= results_seen;
    end

endmodule

// ===== sim/wrapped_rectangle_fill_with_overlap_tb.sv =====
// Testbench top for the wrapped rectangle fill board: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module wrapped_rectangle_fill_with_overlap_tb;
    import bfill_pkg::*;

    localparam int         BOARD_DIM     = 32;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT   = 3_000_000;
    localparam int         PHASE_ITEMS   = 140;
    localparam int         SETTLE_CYCLES = 64;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [1:0]        s_op          = OP_CLEAR;
    logic signed [6:0] s_left_x      = '0;
    logic signed [6:0] s_top_y       = '0;
    logic signed [6:0] s_right_x     = '0;
    logic signed [6:0] s_bottom_y    = '0;
    logic [7:0]        s_fill_symbol = '0;
    logic [4:0]        s_read_col    = '0;
    logic [4:0]        s_read_row    = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [7:0]        m_cell_value;
    logic              m_op_done;

    int error_count;
    int results_outstanding;
    int results_checked;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int sent_per_op [4] = '{0, 0, 0, 0};

    // Free-running clock.
    always #1 aclk = ~aclk;

    wrapped_rectangle_fill_with_overlap #(
        .BOARD_DIM(BOARD_DIM)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_left_x     (s_left_x),
        .s_top_y      (s_top_y),
        .s_right_x    (s_right_x),
        .s_bottom_y   (s_bottom_y),
        .s_fill_symbol(s_fill_symbol),
        .s_read_col   (s_read_col),
        .s_read_row   (s_read_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_value (m_cell_value),
        .m_op_done    (m_op_done)
    );

    board_fill_checker #(
        .BOARD_DIM(BOARD_DIM)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_left_x           (s_left_x),
        .s_top_y            (s_top_y),
        .s_right_x          (s_right_x),
        .s_bottom_y         (s_bottom_y),
        .s_fill_symbol      (s_fill_symbol),
        .s_read_col         (s_read_col),
        .s_read_row         (s_read_row),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_cell_value       (m_cell_value),
        .m_op_done          (m_op_done),
        .error_count        (error_count),
        .results_outstanding(results_outstanding),
        .results_checked    (results_checked)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, results_outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver backpressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Present one command after an optional random gap and hold it until accepted.
    task automatic send_cmd(
        input logic [1:0] op,
        input int         lx,
        input int         ty,
        input int         rx,
        input int         by,
        input int         sym,
        input int         col,
        input int         row
    );
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_op          <= op;
        s_left_x      <= 7'(lx);
        s_top_y       <= 7'(ty);
        s_right_x     <= 7'(rx);
        s_bottom_y    <= 7'(by);
        s_fill_symbol <= 8'(sym);
        s_read_col    <= 5'(col);
        s_read_row    <= 5'(row);
        s_valid       <= 1'b1;
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        sent_per_op[op]++;
    endtask

    // Stop sending and wait for every owed result.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        int         pick;
        int         shape;
        logic [1:0] op;
        int         lx, ty, rx, by, sym, col, row;
        int         last_col, last_row, last_w, last_h;
        int         phase_idle [4];
        int         phase_stall [4];

        phase_idle  = '{0, 71, 0, 30};
        phase_stall = '{0, 0, 71, 30};
        last_col = 0;
        last_row = 0;
        last_w   = 1;
        last_h   = 1;

        // Hold reset, then let the block finish its power-up sweep on its own.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed commands, no pacing.
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 31, 31);
        send_cmd(OP_DRAW, 0, 0, 31, 31, "A", 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 17, 9);
        // Overlapping draw that also wraps past the right and bottom edges.
        send_cmd(OP_DRAW, 16, 16, 40, 40, "B", 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 20, 20);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 4, 4);
        send_cmd(OP_DRAW, 0, 0, 3, 3, "A", 0, 0);
        // Empty ranges, by columns and by rows.
        send_cmd(OP_DRAW, 5, 2, 4, 9, "C", 0, 0);
        send_cmd(OP_DRAW, 2, 7, 9, 6, "C", 0, 0);
        send_cmd(OP_UNUSED, 63, 63, 63, 63, 255, 31, 31);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 2, 2);
        send_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        // Full coordinate span: every cell is visited many times over.
        send_cmd(OP_DRAW, -64, -64, 63, 63, 0, 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 31);
        send_cmd(OP_DRAW, -1, -32, -1, -32, 255, 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 31, 0);
        send_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        // Symbols equal to the empty and overlap codes.
        send_cmd(OP_DRAW, 10, 10, 12, 12, EMPTY_CODE, 0, 0);
        send_cmd(OP_DRAW, 11, 11, 14, 14, OVERLAP_CODE, 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 11, 11);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 14, 14);
        send_cmd(OP_DRAW, -32, -32, 63, 63, 8'h80, 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        drain_results();

        // Random commands across the pacing phases, draining at each boundary.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                lx  = int'($urandom_range(0, 127)) - 64;
                ty  = int'($urandom_range(0, 127)) - 64;
                rx  = int'($urandom_range(0, 127)) - 64;
                by  = int'($urandom_range(0, 127)) - 64;
                sym = $urandom_range(0, 255);
                col = $urandom_range(0, 31);
                row = $urandom_range(0, 31);
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    op = OP_CLEAR;
                end else if (pick < 7) begin
                    op = OP_UNUSED;
                end else if (pick < 50) begin
                    op    = OP_DRAW;
                    shape = $urandom_range(0, 99);
                    if (shape < 6) begin
                        // Empty range on one axis.
                        if (shape < 3) begin
                            lx = int'($urandom_range(0, 126)) - 63;
                            rx = int'($urandom_range(0, lx + 63)) - 64;
                        end else begin
                            ty = int'($urandom_range(0, 126)) - 63;
                            by = int'($urandom_range(0, ty + 63)) - 64;
                        end
                    end else if (shape < 12) begin
                        // Large rectangle, possibly wider than the board.
                        rx = int'($urandom_range(lx + 64, 127)) - 64;
                        by = int'($urandom_range(ty + 64, 127)) - 64;
                    end else begin
                        rx = lx + int'($urandom_range(0, 9));
                        by = ty + int'($urandom_range(0, 9));
                        if (rx > 63) rx = 63;
                        if (by > 63) by = 63;
                    end
                    // A small symbol set makes repeated and overlapping draws common.
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        sym = "a" + $urandom_range(0, 3);
                    end else if (pick < 80) begin
                        sym = EMPTY_CODE;
                    end else if (pick < 85) begin
                        sym = OVERLAP_CODE;
                    end
                    if (rx >= lx && by >= ty) begin
                        last_col = lx;
                        last_row = ty;
                        last_w   = (rx - lx + 1 > BOARD_DIM) ? BOARD_DIM : rx - lx + 1;
                        last_h   = (by - ty + 1 > BOARD_DIM) ? BOARD_DIM : by - ty + 1;
                    end
                end else begin
                    op = OP_READ;
                    // Most reads look inside the last drawn rectangle.
                    if ($urandom_range(0, 99) < 60) begin
                        col = last_col + int'($urandom_range(0, last_w - 1));
                        row = last_row + int'($urandom_range(0, last_h - 1));
                    end
                end
                send_cmd(op, lx, ty, rx, by, sym, col, row);
            end
            drain_results();
        end

        // Quiet tail to catch any stray result transaction.
        idle_pct  = 0;
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Run covered %0d commands: %0d clears, %0d draws, %0d reads, %0d unused codes.",
                 sent_per_op[0] + sent_per_op[1] + sent_per_op[2] + sent_per_op[3],
                 sent_per_op[OP_CLEAR], sent_per_op[OP_DRAW], sent_per_op[OP_READ],
                 sent_per_op[OP_UNUSED]);
        $display("%0d results compared over four pacing phases; %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0 && results_outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
